[rtl/pbr_pkg.sv]
// Package: shared types and constants for the polynomial bisection root block.
`timescale 1ns / 1ps
package pbr_pkg;

  localparam int unsigned MaxDegreeDef = 6;
  localparam int unsigned FracBitsDef  = 20;
  localparam int unsigned MaxSteps     = 64;
  localparam int unsigned CoefW        = 16;
  localparam int unsigned XW           = 32;
  localparam int unsigned AccW         = 64;
  localparam int unsigned CntW         = 7;
  localparam int unsigned CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] RegDegree = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_A,
    ST_EVAL_B,
    ST_CHECK,
    ST_EVAL_M,
    ST_STEP,
    ST_OUT
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input beat
    logic start_a;    // start Horner at low end
    logic start_b;    // start Horner at high end
    logic start_m;    // start Horner at midpoint
    logic save_fa;
    logic save_fb;
    logic narrow;     // apply bisection update
    logic out_valid_set;
    logic out_invalid; // result is the shared-sign report
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic horner_done;
    logic same_sign;
    logic last_step;
  } stat_t;

endpackage

[rtl/polynomial_bisection_root.sv]
// Polynomial bisection root finder: top level with configuration registers.
// One item at a time: the first result follows the Horner passes at both ends and, unless
// their values share a sign, at the midpoint; each further result follows its own midpoint
// pass, which starts once the previous result is taken. Speed is set by the shared 32x32
// multiplier, and a new item is accepted only after the last result is taken.
// Reset: asynchronous active low; clears the controller and configuration registers.
`timescale 1ns / 1ps
module polynomial_bisection_root import pbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MaxDegreeDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW:0]        cfg_index_i,
  input  logic [CoefW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [XW-1:0]    low_end_i,
  input  logic signed [XW-1:0]    high_end_i,
  input  logic [CntW-1:0]         step_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [XW-1:0]    new_low_o,
  output logic signed [XW-1:0]    new_high_o,
  output logic signed [AccW-1:0]  mid_value_o,
  output logic                    status_o,
  output logic                    last_o
);

  logic [2:0]              degree_q;
  logic signed [CoefW-1:0] coef_q [MAX_DEGREE+1];
  cmd_t                    cmd;
  stat_t                   stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
      for (int k = 0; k <= MAX_DEGREE; k++) coef_q[k] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == {1'b0, RegDegree}) degree_q <= cfg_data_i[2:0];
      for (int k = 0; k <= MAX_DEGREE; k++)
        if (cfg_index_i == (CfgIdxW+1)'(k + 1)) coef_q[k] <= cfg_data_i;
    end
  end

  pbr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o (cmd), .stat_i (stat)
  );

  pbr_datapath #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .stat_o (stat),
    .degree_i (degree_q), .coef_i (coef_q),
    .low_end_i, .high_end_i, .step_count_i,
    .new_low_o, .new_high_o, .mid_value_o, .status_o, .last_o
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");
  a_invalid_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> last_o) else $error("invalid result not last");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o) else $error("no idle after last");
`endif

endmodule

[rtl/pbr_horner.sv]
// Horner evaluator: saturating multiply-adds on a shared 32x32 multiplier.
`timescale 1ns / 1ps
module pbr_horner import pbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MaxDegreeDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [XW-1:0]        x_i,
  input  logic [2:0]                  degree_i,
  input  logic signed [CoefW-1:0]     coef_i [MAX_DEGREE+1],
  output logic                        done_o,
  output logic signed [AccW-1:0]      value_o
);

  localparam int unsigned KW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned PW = AccW + XW;
  localparam int unsigned HW = AccW / 2;

  logic                   busy_q, busy_d;
  logic [1:0]             phase_q, phase_d;
  logic [KW-1:0]          k_q, k_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [AccW-1:0]        ma_q;
  logic [XW-1:0]          mx_q;
  logic                   xneg_q;
  logic                   neg_q;
  logic [AccW-1:0]        plo_q;
  logic [AccW-1:0]        phi_q;
  logic                   done_q;
  logic [KW-1:0]          dsat;
  logic [HW-1:0]          mul_a;
  logic [AccW-1:0]        mul_p;
  logic [PW-1:0]          prod;
  logic [AccW-1:0]        mag;
  logic signed [AccW-1:0] mq;
  logic signed [AccW:0]   sum;
  logic signed [AccW-1:0] cterm;

  assign dsat = (degree_i > 3'(MAX_DEGREE)) ? KW'(MAX_DEGREE) : KW'(degree_i);

  function automatic logic signed [AccW-1:0] scale(input logic signed [CoefW-1:0] c);
    scale = AccW'(c) <<< FRAC_BITS;
  endfunction

  // Low half of the accumulator magnitude in phase 1, high half in phase 2.
  assign mul_a = (phase_q == 2'd1) ? ma_q[HW-1:0] : ma_q[AccW-1:HW];
  assign mul_p = AccW'(mul_a) * AccW'(mx_q);
  assign prod  = {{XW{1'b0}}, plo_q} + {phi_q, {HW{1'b0}}};

  always_comb begin
    if (prod[PW-1:AccW+FRAC_BITS] != '0) mag = '1;
    else mag = prod[AccW+FRAC_BITS-1:FRAC_BITS];
    if (neg_q) begin
      if (mag[AccW-1]) mq = {1'b1, {(AccW-1){1'b0}}};
      else mq = -$signed(mag);
    end else begin
      if (mag[AccW-1]) mq = {1'b0, {(AccW-1){1'b1}}};
      else mq = $signed(mag);
    end
    cterm = scale(coef_i[k_q]);
    sum = {mq[AccW-1], mq} + {cterm[AccW-1], cterm};
  end

  always_comb begin
    busy_d = busy_q; phase_d = phase_q; k_d = k_q; acc_d = acc_q;
    if (start_i) begin
      busy_d = (dsat != '0);
      phase_d = 2'd0;
      k_d = dsat;
      acc_d = scale(coef_i[dsat]);
    end else if (busy_q) begin
      phase_d = phase_q + 2'd1;
      if (phase_q == 2'd0) k_d = k_q - KW'(1);
      if (phase_q == 2'd3) begin
        if (sum[AccW] != sum[AccW-1])
          acc_d = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
        else acc_d = sum[AccW-1:0];
        if (k_q == '0) busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; phase_q <= 2'd0; k_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; phase_q <= phase_d; k_q <= k_d;
      done_q <= (start_i && dsat == '0) || (busy_q && phase_q == 2'd3 && k_q == '0);
    end
  end

  // Sign-magnitude product: operands, low partial, high partial, then accumulate.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      mx_q   <= x_i[XW-1] ? XW'(-x_i) : x_i;
      xneg_q <= x_i[XW-1];
    end
    if (phase_q == 2'd0) begin
      ma_q  <= acc_q[AccW-1] ? AccW'(-acc_q) : acc_q;
      neg_q <= acc_q[AccW-1] ^ xneg_q;
    end
    if (phase_q == 2'd1) plo_q <= mul_p;
    if (phase_q == 2'd2) phi_q <= mul_p;
  end

  assign done_o  = done_q;
  assign value_o = acc_q;

endmodule

[rtl/pbr_datapath.sv]
// Datapath: interval registers, endpoint values, midpoint, Horner unit and result register.
`timescale 1ns / 1ps
module pbr_datapath import pbr_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MaxDegreeDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic [2:0]               degree_i,
  input  logic signed [CoefW-1:0]  coef_i [MAX_DEGREE+1],
  input  logic signed [XW-1:0]     low_end_i,
  input  logic signed [XW-1:0]     high_end_i,
  input  logic [CntW-1:0]          step_count_i,
  output logic signed [XW-1:0]     new_low_o,
  output logic signed [XW-1:0]     new_high_o,
  output logic signed [AccW-1:0]   mid_value_o,
  output logic                     status_o,
  output logic                     last_o
);

  logic signed [XW-1:0]   a_q, b_q, mid;
  logic signed [XW:0]     s;
  logic signed [AccW-1:0] fa_q, fb_q, fm;
  logic [CntW-1:0]        n_q, i_q;
  logic                   hdone, opp;
  logic signed [XW-1:0]   hx;

  assign s   = {a_q[XW-1], a_q} + {b_q[XW-1], b_q};
  assign mid = s[XW:1];
  assign hx  = cmd_i.start_a ? a_q : (cmd_i.start_b ? b_q : mid);

  pbr_horner #(.MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_horner (
    .clk_i, .rst_ni,
    .start_i (cmd_i.start_a | cmd_i.start_b | cmd_i.start_m),
    .x_i     (hx),
    .degree_i,
    .coef_i,
    .done_o  (hdone),
    .value_o (fm)
  );

  assign opp = (fm < 0 && fa_q > 0) || (fm > 0 && fa_q < 0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= low_end_i;
      b_q <= high_end_i;
      i_q <= '0;
      if (step_count_i == '0) n_q <= CntW'(1);
      else if (step_count_i > CntW'(MaxSteps)) n_q <= CntW'(MaxSteps);
      else n_q <= step_count_i;
    end
    if (cmd_i.save_fa) fa_q <= fm;
    if (cmd_i.save_fb) fb_q <= fm;
    if (cmd_i.narrow) begin
      i_q <= i_q + 1'b1;
      mid_value_o <= fm;
      if (opp) begin
        if (mid < a_q) begin b_q <= a_q; a_q <= mid; end
        else b_q <= mid;
      end else begin
        if (mid < b_q) a_q <= mid;
        else b_q <= mid;
      end
      status_o <= 1'b0;
      last_o <= (i_q + 1'b1 == n_q);
    end
    if (cmd_i.out_invalid) begin
      mid_value_o <= '0;
      status_o <= 1'b1;
      last_o <= 1'b1;
    end
  end

  assign new_low_o  = a_q;
  assign new_high_o = b_q;
  assign stat_o.horner_done = hdone;
  assign stat_o.same_sign = (fa_q < 0 && fb_q < 0) || (fa_q > 0 && fb_q > 0);
  assign stat_o.last_step = last_o;

endmodule

[rtl/pbr_ctrl.sv]
// Controller: sequences endpoint checks, halvings and result handshakes.
`timescale 1ns / 1ps
module pbr_ctrl import pbr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;
  logic   entered_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL_A;
      ST_EVAL_A: if (stat_i.horner_done) state_d = ST_EVAL_B;
      ST_EVAL_B: if (stat_i.horner_done) state_d = ST_CHECK;
      ST_CHECK:  state_d = stat_i.same_sign ? ST_OUT : ST_EVAL_M;
      ST_EVAL_M: if (stat_i.horner_done) state_d = ST_STEP;
      ST_STEP:   state_d = ST_OUT;
      ST_OUT:    if (out_ready_i)
                   state_d = stat_i.last_step ? ST_IDLE : ST_EVAL_M;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) entered_q <= 1'b0;
    else entered_q <= (state_d != state_q);
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:   begin in_ready_o = 1'b1; cmd_o.load = 1'b1; end
      ST_EVAL_A: begin
        cmd_o.start_a = entered_q;
        cmd_o.save_fa = stat_i.horner_done;
      end
      ST_EVAL_B: begin
        cmd_o.start_b = entered_q;
        cmd_o.save_fb = stat_i.horner_done;
      end
      ST_CHECK:  cmd_o.out_invalid = stat_i.same_sign;
      ST_EVAL_M: cmd_o.start_m = entered_q;
      ST_STEP:   cmd_o.narrow = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default:   ;
    endcase
  end

endmodule

[tb/tb_polynomial_bisection_root.sv]
// Testbench for the polynomial bisection root block: directed and random intervals checked per beat.
`timescale 1ns / 1ps
module tb_polynomial_bisection_root;
  import pbr_pkg::*;

  typedef struct packed {
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic [CntW-1:0]      steps;
  } item_t;

  typedef struct packed {
    logic signed [XW-1:0]   lo;
    logic signed [XW-1:0]   hi;
    logic signed [AccW-1:0] fmid;
    logic                   status;
    logic                   last;
  } step_res_t;

  localparam int unsigned RegCoef0 = 1;
  localparam int unsigned RegLimit = 8;
  localparam longint SatMax = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SatMin = -64'sh7fff_ffff_ffff_ffff - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW:0] cfg_index_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [XW-1:0] low_end_i = '0;
  logic signed [XW-1:0] high_end_i = '0;
  logic [CntW-1:0] step_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [XW-1:0] new_low_o;
  logic signed [XW-1:0] new_high_o;
  logic signed [AccW-1:0] mid_value_o;
  logic status_o;
  logic last_o;

  polynomial_bisection_root u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  item_t pending_items[$];
  step_res_t expected_steps[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_beats = 0;
  int unsigned n_invalid = 0;
  longint unsigned cycles = 0;

  logic [2:0] deg_reg = '0;
  logic signed [CoefW-1:0] coefs[7];

  function automatic longint sadd(longint a, longint b);
    if (b > 0 && a > SatMax - b) return SatMax;
    if (b < 0 && a < SatMin - b) return SatMin;
    return a + b;
  endfunction

  function automatic longint mulq(longint acc, longint x);
    logic signed [127:0] p;
    logic [127:0] mag;
    bit neg;
    p = 128'(signed'(acc)) * 128'(signed'(x));
    neg = p < 0;
    mag = neg ? -p : p;
    mag = mag >> FracBitsDef;
    if (neg) begin
      if (mag >= 128'h8000_0000_0000_0000) return SatMin;
      return -longint'(mag[63:0]);
    end
    if (mag > 128'h7fff_ffff_ffff_ffff) return SatMax;
    return longint'(mag[63:0]);
  endfunction

  function automatic longint horner(longint x);
    int d;
    longint acc;
    d = (deg_reg > MaxDegreeDef) ? MaxDegreeDef : deg_reg;
    acc = longint'(coefs[d]) <<< FracBitsDef;
    for (int k = d - 1; k >= 0; k--)
      acc = sadd(mulq(acc, x), longint'(coefs[k]) <<< FracBitsDef);
    return acc;
  endfunction

  task automatic predict_bisection(item_t it);
    longint a, b, f1, f2, s, mid, fm;
    int n;
    bit opp;
    step_res_t r;
    a = it.lo;
    b = it.hi;
    f1 = horner(a);
    f2 = horner(b);
    if ((f1 < 0 && f2 < 0) || (f1 > 0 && f2 > 0)) begin
      r = '{lo: it.lo, hi: it.hi, fmid: '0, status: 1'b1, last: 1'b1};
      expected_steps.push_back(r);
      n_invalid++;
      return;
    end
    n = it.steps;
    if (n == 0) n = 1;
    if (n > MaxSteps) n = MaxSteps;
    for (int i = 0; i < n; i++) begin
      s = a + b;
      mid = s >>> 1;
      fm = horner(mid);
      opp = (fm < 0 && f1 > 0) || (fm > 0 && f1 < 0);
      if (opp) begin
        if (mid < a) begin
          b = a;
          a = mid;
        end else b = mid;
      end else if (mid < b) a = mid;
      else b = mid;
      r = '{lo: a[31:0], hi: b[31:0], fmid: fm, status: 1'b0, last: (i == n - 1)};
      expected_steps.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_bisection('{lo: low_end_i, hi: high_end_i, steps: step_count_i});
        n_items++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_t it;
          it = pending_items.pop_front();
          in_valid_i <= 1'b1;
          low_end_i <= it.lo;
          high_end_i <= it.hi;
          step_count_i <= it.steps;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        step_res_t got, want;
        got = '{lo: new_low_o, hi: new_high_o, fmid: mid_value_o, status: status_o,
                last: last_o};
        n_beats++;
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          errors++;
        end else begin
          want = expected_steps.pop_front();
          if (got.lo !== want.lo)
            $display("%0t: new_low exp %0d got %0d", $time, want.lo, got.lo);
          if (got.hi !== want.hi)
            $display("%0t: new_high exp %0d got %0d", $time, want.hi, got.hi);
          if (got.fmid !== want.fmid)
            $display("%0t: mid_value exp %0d got %0d", $time, want.fmid, got.fmid);
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got.last !== want.last)
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      out_ready_i <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 10_000_000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(int unsigned idx, logic [CoefW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CfgIdxW:0];
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegDegree) deg_reg = val[2:0];
    else if (idx < RegLimit) coefs[idx - RegCoef0] = val;
  endtask

  task automatic cfg_idle();
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_steps.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic item_t rand_item(int unsigned span);
    item_t it;
    int signed a;
    a = $urandom;
    case ($urandom_range(9))
      0: begin it.lo = $urandom; it.hi = $urandom; end
      1: begin it.lo = $urandom_range(span) - span / 2; it.hi = $urandom; end
      default: begin
        it.lo = a % (span * 1024 + 1);
        it.hi = it.lo + $urandom_range(span * 4096);
      end
    endcase
    it.steps = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 12));
    return it;
  endfunction

  task automatic load_poly(logic [2:0] d, int signed c[7]);
    write_reg(RegDegree, CoefW'(d));
    for (int k = 0; k < 7; k++) write_reg(RegCoef0 + k, c[k][CoefW-1:0]);
    cfg_idle();
  endtask

  initial begin
    item_t it;
    for (int k = 0; k < 7; k++) coefs[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // x^2 - 2: root near sqrt(2)
    load_poly(3'd2, '{-2, 0, 1, 0, 0, 0, 0});
    pending_items.push_back('{lo: 32'sd0, hi: 32'sd2 <<< 20, steps: 7'd20});
    pending_items.push_back('{lo: 32'sd2 <<< 20, hi: 32'sd0, steps: 7'd5});
    pending_items.push_back('{lo: 32'sd3 <<< 20, hi: 32'sd4 <<< 20, steps: 7'd3});
    pending_items.push_back('{lo: -32'sd2 <<< 20, hi: -32'sd1 <<< 20, steps: 7'd0});
    pending_items.push_back('{lo: 32'sh8000_0000, hi: 32'sh7fff_ffff, steps: 7'd64});
    pending_items.push_back('{lo: 32'sh7fff_ffff, hi: 32'sh7fff_ffff, steps: 7'd127});
    pending_items.push_back('{lo: 32'sh8000_0000, hi: 32'sh8000_0000, steps: 7'd1});
    pending_items.push_back('{lo: -32'sd1, hi: 32'sd1, steps: 7'd65});
    drain();

    // sixth-degree extremes, saturating sums; degree field above limit
    load_poly(3'd7, '{-32768, 32767, -32768, 32767, -32768, 32767, -32768});
    pending_items.push_back('{lo: 32'sh8000_0000, hi: 32'sh7fff_ffff, steps: 7'd10});
    pending_items.push_back('{lo: -32'sd1 <<< 20, hi: 32'sd1 <<< 20, steps: 7'd16});
    pending_items.push_back('{lo: 32'sd0, hi: 32'sd0, steps: 7'd2});
    drain();
    write_reg(RegDegree, CoefW'(6));
    write_reg(RegLimit, 16'hffff);
    cfg_idle();
    pending_items.push_back('{lo: 32'sh4000_0000, hi: -32'sd5, steps: 7'd8});
    drain();

    // random polynomials; nine phases in three idling settings
    for (int ph = 0; ph < 9; ph++) begin
      int signed c[7];
      for (int k = 0; k < 7; k++)
        c[k] = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(20)) - 10;
      load_poly(ph == 0 ? 3'd0 : 3'($urandom_range(7)), c);
      send_idle_pct = (ph < 3) ? 26 : (ph < 6) ? 79 : 0;
      recv_idle_pct = (ph < 3) ? 79 : (ph < 6) ? 26 : 0;
      for (int i = 0; i < 46; i++) begin
        it = rand_item(ph < 4 ? 64 : 1 << 18);
        pending_items.push_back(it);
      end
      if (ph == 7) begin
        hold_recv = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      drain();
    end

    $display("Covered %0d intervals, %0d result beats, %0d with no sign change.",
             n_items, n_beats, n_invalid);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
